// ===== hw/rtl/piaw_pkg.sv =====
// Shared types, widths and helpers for the PI controller with anti-windup.
// No dependencies; imported by every module of the block.
package piaw_pkg;

    localparam int DATA_W    = 16;  // setpoint, measured, drive, clamp limits
    localparam int GAIN_W    = 8;   // kp, ki, kc
    localparam int CFG_IDX_W = 3;
    localparam int ERR_W     = DATA_W + 1;
    localparam int MB_W      = 25;  // signed B operand of the shared multiplier
    localparam int PROD_W    = GAIN_W + 1 + MB_W;
    localparam int ACC_W     = 48;  // integral and clip error
    localparam int WACC_W    = 58;  // wide accumulator before saturation
    localparam int SUM_W     = ACC_W + 1;
    localparam int DIFF_W    = ACC_W + 2;
    localparam int HALF_W    = ACC_W / 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [DATA_W-1:0] RESET_OUT_MAX = 16'd1520;
    localparam logic [DATA_W-1:0] RESET_OUT_MIN = 16'd1;
    localparam logic [GAIN_W-1:0] RESET_GAIN    = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KC      = 3'd2,
        CFG_OUT_MAX = 3'd3,
        CFG_OUT_MIN = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MSEL_KP_ERR  = 2'd0,
        MSEL_KI_PROP = 2'd1,
        MSEL_KC_LO   = 2'd2,
        MSEL_KC_HI   = 2'd3
    } t_msel;

    typedef struct packed {
        logic  busy;       // item in flight, input side stalled
        logic  load;       // item accepted this cycle
        t_msel msel;       // multiplier operand pair
        logic  acc_init;   // load accumulator with the integral
        logic  acc_add;    // add registered product into accumulator
        logic  acc_shift;  // product is the upper clip half, weight 2^24
        logic  sat;        // saturate accumulator into the integral
        logic  sum;        // form prop + integral
        logic  clamp;      // clamp the sum
        logic  fin;        // update clip error and load the output register
    } t_ctrl;

    function automatic logic signed [ACC_W-1:0] sat_wide(input logic signed [WACC_W-1:0] v);
        logic [WACC_W-ACC_W:0] top;
        top = v[WACC_W-1:ACC_W-1];
        if ((&top) || !(|top)) begin
            return v[ACC_W-1:0];
        end
        return v[WACC_W-1] ? ACC_MIN : ACC_MAX;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_diff(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-ACC_W:0] top;
        top = v[DIFF_W-1:ACC_W-1];
        if ((&top) || !(|top)) begin
            return v[ACC_W-1:0];
        end
        return v[DIFF_W-1] ? ACC_MIN : ACC_MAX;
    endfunction

endpackage

// ===== hw/rtl/piaw_mul.sv =====
// Shared 8x25 multiplier with registered product, used for all three gains.
// Depends on piaw_pkg for widths.
module piaw_mul import piaw_pkg::*; (
    input  logic                     i_clk,
    input  logic [GAIN_W-1:0]        i_a,
    input  logic signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [GAIN_W:0]   a_ext;

    // gain is unsigned: widen with a zero sign bit
    assign a_ext  = $signed({1'b0, i_a});
    assign n_prod = PROD_W'(a_ext) * PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/piaw_ctrl.sv =====
// Step sequencer: walks one item through the shared multiplier and adders.
// Depends on piaw_pkg for the control struct.
module piaw_ctrl import piaw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output t_ctrl o_ctrl
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_P     = 10'b00_0000_0010,
        S_I     = 10'b00_0000_0100,
        S_CL    = 10'b00_0000_1000,
        S_CH    = 10'b00_0001_0000,
        S_ADDH  = 10'b00_0010_0000,
        S_SAT   = 10'b00_0100_0000,
        S_SUM   = 10'b00_1000_0000,
        S_CLAMP = 10'b01_0000_0000,
        S_CLIP  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_P;
            S_P:     n_state = S_I;
            S_I:     n_state = S_CL;
            S_CL:    n_state = S_CH;
            S_CH:    n_state = S_ADDH;
            S_ADDH:  n_state = S_SAT;
            S_SAT:   n_state = S_SUM;
            S_SUM:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_CLIP;
            // hold until the output register can take the item
            S_CLIP:  if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctrl           = '0;
        o_ctrl.msel      = MSEL_KP_ERR;
        o_ctrl.busy      = (r_state != S_IDLE);
        o_ctrl.load      = (r_state == S_IDLE) && i_in_valid;
        o_ctrl.fin       = (r_state == S_CLIP) && i_out_free;
        o_ctrl.sat       = (r_state == S_SAT);
        o_ctrl.sum       = (r_state == S_SUM);
        o_ctrl.clamp     = (r_state == S_CLAMP);
        o_ctrl.acc_init  = (r_state == S_I);
        o_ctrl.acc_add   = (r_state == S_CL) || (r_state == S_CH) || (r_state == S_ADDH);
        o_ctrl.acc_shift = (r_state == S_ADDH);
        case (r_state)
            S_I:     o_ctrl.msel = MSEL_KI_PROP;
            S_CL:    o_ctrl.msel = MSEL_KC_LO;
            S_CH:    o_ctrl.msel = MSEL_KC_HI;
            default: o_ctrl.msel = MSEL_KP_ERR;
        endcase
    end

endmodule

// ===== hw/rtl/pi_controller_antiwindup.sv =====
// Top level: PI controller with back-calculation anti-windup.
// Depends on piaw_pkg, piaw_mul and piaw_ctrl.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_setpoint, i_measured
//  out     | from block| o_out_valid / i_out_stall | o_drive
//  cfg     | to block  | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// An item goes from acceptance to a loaded output register through four shared
// multiplier passes (kp, ki, kc on each clip-error half), then saturate, sum,
// clamp and clip-error steps; the input stays stalled until the output register
// is loaded, so a new item is only taken once the last one is through.
// The output register lets a finished drive wait while the next item is taken;
// a stalled output holds the sequencer in its last step until the register frees.
// Reset is synchronous, active low, and restores gains, limits and both states.
module pi_controller_antiwindup import piaw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_setpoint,
    input  logic signed [DATA_W-1:0] i_measured,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_drive,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    t_ctrl ctrl;

    logic [GAIN_W-1:0]        r_kp, r_ki, r_kc;
    logic signed [DATA_W-1:0] r_out_max, r_out_min;

    logic signed [ACC_W-1:0]  r_integ, r_clip;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [MB_W-1:0]   r_prop;
    logic signed [WACC_W-1:0] r_acc;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DATA_W-1:0] r_drv;
    logic signed [DATA_W-1:0] r_out_drive;
    logic                     r_out_valid;

    logic [GAIN_W-1:0]        mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [WACC_W-1:0] addend;
    logic signed [DATA_W-1:0] n_drv;
    logic signed [DIFF_W-1:0] diff;
    logic                     out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    piaw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    always_comb begin
        case (ctrl.msel)
            MSEL_KP_ERR: begin
                mul_a = r_kp;
                mul_b = MB_W'(r_err);
            end
            MSEL_KI_PROP: begin
                mul_a = r_ki;
                mul_b = prod[MB_W-1:0];
            end
            MSEL_KC_LO: begin
                mul_a = r_kc;
                mul_b = $signed({1'b0, r_clip[HALF_W-1:0]});
            end
            MSEL_KC_HI: begin
                mul_a = r_kc;
                mul_b = MB_W'($signed(r_clip[ACC_W-1:HALF_W]));
            end
            default: begin
                mul_a = r_kp;
                mul_b = MB_W'(r_err);
            end
        endcase
    end

    piaw_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // upper clip half carries weight 2^24
    assign addend = ctrl.acc_shift ? $signed({prod, {HALF_W{1'b0}}}) : WACC_W'(prod);

    always_comb begin
        if (r_sum > SUM_W'(r_out_max)) begin
            n_drv = r_out_max;
        end else if (r_sum < SUM_W'(r_out_min)) begin
            n_drv = r_out_min;
        end else begin
            n_drv = r_sum[DATA_W-1:0];
        end
    end

    assign diff = DIFF_W'(r_drv) - DIFF_W'(r_sum);

    // configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= RESET_GAIN;
            r_ki        <= RESET_GAIN;
            r_kc        <= RESET_GAIN;
            r_out_max   <= RESET_OUT_MAX;
            r_out_min   <= RESET_OUT_MIN;
            r_integ     <= '0;
            r_clip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:      r_kp      <= i_cfg_data[GAIN_W-1:0];
                    CFG_KI:      r_ki      <= i_cfg_data[GAIN_W-1:0];
                    CFG_KC:      r_kc      <= i_cfg_data[GAIN_W-1:0];
                    CFG_OUT_MAX: r_out_max <= i_cfg_data;
                    CFG_OUT_MIN: r_out_min <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.sat) begin
                r_integ <= sat_wide(r_acc);
            end
            if (ctrl.fin) begin
                r_clip      <= sat_diff(diff);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_err <= ERR_W'(i_setpoint) - ERR_W'(i_measured);
        end
        if (ctrl.acc_init) begin
            r_prop <= prod[MB_W-1:0];
            r_acc  <= WACC_W'(r_integ);
        end else if (ctrl.acc_add) begin
            r_acc <= r_acc + addend;
        end
        if (ctrl.sum) begin
            r_sum <= SUM_W'(r_prop) + SUM_W'(r_integ);
        end
        if (ctrl.clamp) begin
            r_drv <= n_drv;
        end
        if (ctrl.fin) begin
            r_out_drive <= r_drv;
        end
    end

    assign o_in_stall  = ctrl.busy;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;

endmodule

// ===== hw/rtl/piaw_checker.sv =====
// Port-level checks for the PI controller, attached to the top level by bind.
// Depends on piaw_pkg for widths.
module piaw_checker import piaw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] o_drive
);

    // a held result keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("drive item dropped while stalled");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_drive))
        else $error("drive changed while stalled");

    // one item at a time: taking an item makes the block busy
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken without going busy");

    // a new result only appears at the end of a busy stretch
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in flight");

    // no result the cycle right after taking an item
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

endmodule

bind pi_controller_antiwindup piaw_checker u_piaw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_drive     (o_drive)
);

// ===== tb/sv/pi_controller_antiwindup_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for pi_controller_antiwindup: feeds setpoint/measured items,
// predicts every drive value with its own PI model and checks the output channel.
// Depends on piaw_pkg and the pi_controller_antiwindup RTL.
module pi_controller_antiwindup_tb import piaw_pkg::*; ();

    typedef struct {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measured;
        bit                       hold_for_drain;  // wait for all drives before sending
    } t_sample;

    typedef enum {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_EVERY_THIRD} t_stall_mode;

    localparam longint INTEG_HI = longint'(ACC_MAX);
    localparam longint INTEG_LO = longint'(ACC_MIN);
    localparam int     RANDOM_SETTINGS = 12;
    localparam int     SAMPLES_PER_SETTING = 66;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_setpoint = '0;
    logic signed [DATA_W-1:0] i_measured = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_drive;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    // controller model: gains, limits and the two accumulators
    logic [GAIN_W-1:0]        gain_p = RESET_GAIN;
    logic [GAIN_W-1:0]        gain_i = RESET_GAIN;
    logic [GAIN_W-1:0]        gain_c = RESET_GAIN;
    logic signed [DATA_W-1:0] lim_hi = RESET_OUT_MAX;
    logic signed [DATA_W-1:0] lim_lo = RESET_OUT_MIN;
    longint                   integ_acc = 0;
    longint                   clip_err = 0;

    t_sample                  sample_queue[$];
    logic signed [DATA_W-1:0] drive_expected[$];
    t_sample                  next_sample;
    int                       samples_queued = 0;
    int                       samples_taken = 0;
    int                       drives_checked = 0;
    int                       fault_count = 0;
    int                       settings_count = 1;
    int                       clamp_count = 0;
    int                       sat_hits = 0;
    int                       burst_left = 0;
    int                       gap_left = 0;
    int                       stall_tick = 0;
    int                       stall_run = 0;
    t_stall_mode              stall_mode = STALL_NONE;
    logic                     stall_next;
    logic signed [DATA_W-1:0] drive_want;

    pi_controller_antiwindup dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint clip48(input longint v);
        if (v > INTEG_HI) begin
            sat_hits++;
            return INTEG_HI;
        end
        if (v < INTEG_LO) begin
            sat_hits++;
            return INTEG_LO;
        end
        return v;
    endfunction

    // advance the accumulators by one item and return the clamped drive
    function automatic logic signed [DATA_W-1:0] predict_drive(
            input logic signed [DATA_W-1:0] sp,
            input logic signed [DATA_W-1:0] ms);
        longint err;
        longint prop;
        longint sum;
        longint drv;
        err       = longint'(sp) - longint'(ms);
        prop      = longint'(gain_p) * err;
        integ_acc = clip48(integ_acc + longint'(gain_i) * prop + longint'(gain_c) * clip_err);
        sum       = prop + integ_acc;
        // upper limit is checked first, so it wins when the sum crosses both limits
        if (sum > longint'(lim_hi)) begin
            drv = longint'(lim_hi);
            clamp_count++;
        end else if (sum < longint'(lim_lo)) begin
            drv = longint'(lim_lo);
            clamp_count++;
        end else begin
            drv = sum;
        end
        clip_err = clip48(drv - sum);
        return DATA_W'(drv);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic log_fault(input string what, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // call right after a rising edge; the write lands on the next one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_KP:      gain_p = data[GAIN_W-1:0];
            CFG_KI:      gain_i = data[GAIN_W-1:0];
            CFG_KC:      gain_c = data[GAIN_W-1:0];
            CFG_OUT_MAX: lim_hi = data;
            CFG_OUT_MIN: lim_lo = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                  input logic [GAIN_W-1:0] kc,
                                  input logic signed [DATA_W-1:0] hi,
                                  input logic signed [DATA_W-1:0] lo);
        // junk in the upper byte of gain writes must be dropped
        cfg_write(CFG_KP, {8'($urandom), kp});
        cfg_write(CFG_KI, {8'($urandom), ki});
        cfg_write(CFG_KC, {8'($urandom), kc});
        cfg_write(CFG_OUT_MAX, hi);
        cfg_write(CFG_OUT_MIN, lo);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic queue_sample(input logic signed [DATA_W-1:0] sp,
                                input logic signed [DATA_W-1:0] ms, input bit hold);
        t_sample s;
        s.setpoint       = sp;
        s.measured       = ms;
        s.hold_for_drain = hold;
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    task automatic queue_random_sample();
        logic signed [DATA_W-1:0] sp;
        logic signed [DATA_W-1:0] ms;
        sp = DATA_W'($urandom);
        case ($urandom_range(0, 4))
            0, 1: ms = DATA_W'($urandom);
            2, 3: ms = DATA_W'(sp + $urandom_range(0, 128) - 64);
            default: begin
                sp = DATA_W'($urandom_range(0, 4000) - 2000);
                ms = DATA_W'($urandom_range(0, 4000) - 2000);
            end
        endcase
        queue_sample(sp, ms, $urandom_range(0, 39) == 0);
    endtask

    // hold until every queued item is taken and every drive has come back
    task automatic wait_idle();
        while (samples_taken != samples_queued || drive_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    // input side: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                drive_expected.push_back(predict_drive(i_setpoint, i_measured));
                samples_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() != 0 &&
                             !(sample_queue[0].hold_for_drain && drive_expected.size() != 0)) begin
                    next_sample = sample_queue.pop_front();
                    i_setpoint <= next_sample.setpoint;
                    i_measured <= next_sample.measured;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each drive and stall on a changing pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (drive_expected.size() == 0) begin
                    log_fault("drive with no item outstanding", '0, o_drive);
                end else begin
                    drive_want = drive_expected.pop_front();
                    drives_checked++;
                    if (o_drive !== drive_want) begin
                        log_fault("drive mismatch", drive_want, o_drive);
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 150 == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
            end
            case (stall_mode)
                STALL_NONE: stall_next = 1'b0;
                STALL_COIN: stall_next = ($urandom_range(0, 1) == 1);
                STALL_RUNS: begin
                    if (stall_run > 0) begin
                        stall_run--;
                        stall_next = i_out_stall;
                    end else begin
                        stall_next = !i_out_stall;
                        stall_run  = $urandom_range(0, 20);
                    end
                end
                default: stall_next = (stall_tick % 3 == 0);
            endcase
            i_out_stall <= stall_next;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains and limits: clamp both ways, extreme fields
        queue_sample(16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd100, 16'sd0, 1'b0);
        queue_sample(16'sd2000, 16'sd0, 1'b0);
        queue_sample(-16'sd2000, 16'sd0, 1'b0);
        queue_sample(16'sh7FFF, 16'sh8000, 1'b0);
        queue_sample(16'sh8000, 16'sh7FFF, 1'b0);
        queue_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 16'sh8000, 1'b0);
        wait_idle();

        // full gains and widest limits drive both accumulators into saturation;
        // writes to unmapped indexes must change nothing
        apply_settings('1, '1, '1, 16'sh7FFF, 16'sh8000);
        for (int k = 1; k <= 3; k++) begin
            cfg_write(CFG_IDX_W'(CFG_OUT_MIN + k), DATA_W'($urandom));
        end
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 3; k++) begin
            queue_sample(16'sh7FFF, 16'sh8000, 1'b0);
        end
        for (int k = 0; k < 3; k++) begin
            queue_sample(16'sh8000, 16'sh7FFF, 1'b0);
        end
        queue_sample(16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd1, 16'sd0, 1'b1);
        wait_idle();

        // crossed limits at the extremes, zero kp and ki gains
        apply_settings('0, '0, 8'd1, 16'sh8000, 16'sh7FFF);
        queue_sample(16'sd0, 16'sd0, 1'b0);
        queue_sample(16'sd5, -16'sd5, 1'b0);
        queue_sample(16'sh8000, 16'sh7FFF, 1'b0);
        queue_sample(16'sh7FFF, 16'sh8000, 1'b0);
        queue_sample(16'sd123, 16'sd456, 1'b0);
        queue_sample(16'sd0, 16'sd0, 1'b0);

        for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
            logic [GAIN_W-1:0]        kp;
            logic [GAIN_W-1:0]        ki;
            logic [GAIN_W-1:0]        kc;
            logic signed [DATA_W-1:0] hi;
            logic signed [DATA_W-1:0] lo;
            wait_idle();
            kp = pick_gain();
            ki = pick_gain();
            // kc of one pulls a wound-up integral back, so favor it
            kc = ($urandom_range(0, 1) == 1) ? 8'd1 : pick_gain();
            case ($urandom_range(0, 5))
                0: begin
                    hi = 16'sh7FFF;
                    lo = 16'sh8000;
                end
                1: begin
                    lo = DATA_W'($urandom_range(0, 3000));
                    hi = DATA_W'(lo - $urandom_range(1, 3000));
                end
                2: begin
                    hi = DATA_W'($urandom);
                    lo = DATA_W'($urandom);
                end
                default: begin
                    hi = DATA_W'($urandom_range(0, 3000));
                    lo = DATA_W'(-$urandom_range(0, 3000));
                end
            endcase
            apply_settings(kp, ki, kc, hi, lo);
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(CFG_IDX_W'(CFG_OUT_MIN + $urandom_range(1, 3)), DATA_W'($urandom));
                i_cfg_we <= 1'b0;
            end
            for (int k = 0; k < SAMPLES_PER_SETTING; k++) begin
                queue_random_sample();
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (drive_expected.size() != 0) begin
            $display("%0d drive values never arrived", drive_expected.size());
            fault_count += drive_expected.size();
        end
        $display("covered %0d items under %0d gain/limit settings, %0d drives checked",
                 samples_taken, settings_count, drives_checked);
        $display("  %0d drives clamped, %0d accumulator saturations, %0d faults",
                 clamp_count, sat_hits, fault_count);
        if (fault_count == 0) begin
            $display("pi_controller_antiwindup_tb OK");
        end else begin
            $display("pi_controller_antiwindup_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d of %0d items taken, %0d drives pending",
                 samples_taken, samples_queued, drive_expected.size());
        $display("pi_controller_antiwindup_tb NOT OK");
        $finish;
    end

endmodule
